// ===== hw/rtl/aabb_affine_transform_top_macros.svh =====
// Assertion macros for the box transform block.
`ifndef AABB_AFFINE_TRANSFORM_TOP_MACROS_SVH
`define AABB_AFFINE_TRANSFORM_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define AAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/aat_pkg.sv =====
`timescale 1ns / 1ps

package aat_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned COEF_WIDTH  = 16;
  localparam int unsigned COEF_FRAC   = 14;
  localparam int unsigned ROW_WIDTH   = 3 * COEF_WIDTH;
  localparam int unsigned SHIFT_WIDTH = 32;
  localparam int unsigned CFG_WIDTH   = ROW_WIDTH;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned LATENCY     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X   = 3'd0,
    CFG_ROW_Y   = 3'd1,
    CFG_ROW_Z   = 3'd2,
    CFG_SHIFT_X = 3'd3,
    CFG_SHIFT_Y = 3'd4,
    CFG_SHIFT_Z = 3'd5
  } cfg_idx_e;

  localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = ROW_WIDTH'(64'd16384);
  localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = ROW_WIDTH'(64'd16384 << 16);
  localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET = ROW_WIDTH'(64'd16384 << 32);

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] box_min_x;
    logic signed [COORD_WIDTH-1:0] box_min_y;
    logic signed [COORD_WIDTH-1:0] box_min_z;
    logic signed [COORD_WIDTH-1:0] box_max_x;
    logic signed [COORD_WIDTH-1:0] box_max_y;
    logic signed [COORD_WIDTH-1:0] box_max_z;
  } box_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_min_x;
    logic signed [COORD_WIDTH-1:0] out_min_y;
    logic signed [COORD_WIDTH-1:0] out_min_z;
    logic signed [COORD_WIDTH-1:0] out_max_x;
    logic signed [COORD_WIDTH-1:0] out_max_y;
    logic signed [COORD_WIDTH-1:0] out_max_z;
    logic                          clipped;
  } res_t;

endpackage

// ===== hw/rtl/aabb_affine_transform_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Word
// box       in         start && !busy        box_i (box_t)
// result    out        valid_o, one cycle    result_o (res_t)
// config    in         cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// A box is taken in every cycle; busy stays low. Its result passes through the
// input register, multiplier stage, adder stage, then floor and saturate into
// the output register. The 16 x COORD_WIDTH multipliers set the stage depth.
// Reset clears the stage valid bits and loads the identity matrix with zero
// translation. The receiver cannot stall, so nothing is held back.

module aabb_affine_transform_top
  import aat_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  box_t                 box_i,
  output logic                 valid_o,
  output res_t                 result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i
);

  localparam int unsigned ProdW = COORD_WIDTH + COEF_WIDTH;
  localparam int unsigned BaseW = (ProdW > SHIFT_WIDTH + COEF_FRAC) ?
                                  ProdW : SHIFT_WIDTH + COEF_FRAC;
  localparam int unsigned SumW  = BaseW + 2;
  localparam int unsigned QuotW = SumW - COEF_FRAC;

  logic [ROW_WIDTH-1:0]   row_q [NUM_AXES];
  logic [SHIFT_WIDTH-1:0] shift_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0]   <= ROW_X_RESET;
      row_q[1]   <= ROW_Y_RESET;
      row_q[2]   <= ROW_Z_RESET;
      shift_q[0] <= '0;
      shift_q[1] <= '0;
      shift_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_X:   row_q[0]   <= cfg_wdata_i;
        CFG_ROW_Y:   row_q[1]   <= cfg_wdata_i;
        CFG_ROW_Z:   row_q[2]   <= cfg_wdata_i;
        CFG_SHIFT_X: shift_q[0] <= cfg_wdata_i[SHIFT_WIDTH-1:0];
        CFG_SHIFT_Y: shift_q[1] <= cfg_wdata_i[SHIFT_WIDTH-1:0];
        CFG_SHIFT_Z: shift_q[2] <= cfg_wdata_i[SHIFT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: input register
  logic v1_q, v2_q, v3_q, v4_q;
  box_t box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      box_q <= box_i;
    end
  end

  // stage 2: pick corners by coefficient sign, multiply
  logic signed [COORD_WIDTH-1:0] in_lo [NUM_AXES];
  logic signed [COORD_WIDTH-1:0] in_hi [NUM_AXES];
  logic signed [COEF_WIDTH-1:0]  coef  [NUM_AXES][NUM_AXES];

  assign in_lo[0] = box_q.box_min_x;
  assign in_lo[1] = box_q.box_min_y;
  assign in_lo[2] = box_q.box_min_z;
  assign in_hi[0] = box_q.box_max_x;
  assign in_hi[1] = box_q.box_max_y;
  assign in_hi[2] = box_q.box_max_z;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        coef[i][j] = signed'(row_q[i][COEF_WIDTH*j +: COEF_WIDTH]);
      end
    end
  end

  logic signed [ProdW-1:0] plo_q [NUM_AXES][NUM_AXES];
  logic signed [ProdW-1:0] phi_q [NUM_AXES][NUM_AXES];

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (!coef[i][j][COEF_WIDTH-1] && (coef[i][j] != '0)) begin
            plo_q[j][i] <= coef[i][j] * in_lo[i];
            phi_q[j][i] <= coef[i][j] * in_hi[i];
          end else begin
            plo_q[j][i] <= coef[i][j] * in_hi[i];
            phi_q[j][i] <= coef[i][j] * in_lo[i];
          end
        end
      end
    end
  end

  // stage 3: exact sums with translation
  logic signed [SumW-1:0] slo_q [NUM_AXES];
  logic signed [SumW-1:0] shi_q [NUM_AXES];
  logic signed [SumW-1:0] tr    [NUM_AXES];

  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      tr[j] = SumW'(signed'(shift_q[j])) <<< COEF_FRAC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        slo_q[j] <= tr[j] + SumW'(plo_q[j][0]) + SumW'(plo_q[j][1]) + SumW'(plo_q[j][2]);
        shi_q[j] <= tr[j] + SumW'(phi_q[j][0]) + SumW'(phi_q[j][1]) + SumW'(phi_q[j][2]);
      end
    end
  end

  // stage 4: floor to Q16.16, saturate
  function automatic logic [COORD_WIDTH:0] sat_floor(logic signed [SumW-1:0] s);
    logic signed [QuotW-1:0] q;
    logic                    fits;
    q    = QuotW'(s >>> COEF_FRAC);
    fits = (q[QuotW-1:COORD_WIDTH-1] == '0) || (q[QuotW-1:COORD_WIDTH-1] == '1);
    if (fits) begin
      return {1'b0, q[COORD_WIDTH-1:0]};
    end
    return {1'b1, (q[QuotW-1] ? COORD_MIN : COORD_MAX)};
  endfunction

  logic [COORD_WIDTH:0] flo [NUM_AXES];
  logic [COORD_WIDTH:0] fhi [NUM_AXES];

  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      flo[j] = sat_floor(slo_q[j]);
      fhi[j] = sat_floor(shi_q[j]);
    end
  end

  res_t res_q;

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      res_q.out_min_x <= flo[0][COORD_WIDTH-1:0];
      res_q.out_min_y <= flo[1][COORD_WIDTH-1:0];
      res_q.out_min_z <= flo[2][COORD_WIDTH-1:0];
      res_q.out_max_x <= fhi[0][COORD_WIDTH-1:0];
      res_q.out_max_y <= fhi[1][COORD_WIDTH-1:0];
      res_q.out_max_z <= fhi[2][COORD_WIDTH-1:0];
      res_q.clipped   <= flo[0][COORD_WIDTH] | flo[1][COORD_WIDTH] | flo[2][COORD_WIDTH] |
                         fhi[0][COORD_WIDTH] | fhi[1][COORD_WIDTH] | fhi[2][COORD_WIDTH];
    end
  end

  assign valid_o  = v4_q;
  assign result_o = res_q;

endmodule

// ===== hw/rtl/aat_checker.sv =====
`timescale 1ns / 1ps

`include "aabb_affine_transform_top_macros.svh"

module aat_checker
  import aat_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o,
  input res_t result_o
);

  logic took;
  logic edge_seen;

  assign took = start && !busy;

  assign edge_seen =
    (result_o.out_min_x == COORD_MAX) || (result_o.out_min_x == COORD_MIN) ||
    (result_o.out_min_y == COORD_MAX) || (result_o.out_min_y == COORD_MIN) ||
    (result_o.out_min_z == COORD_MAX) || (result_o.out_min_z == COORD_MIN) ||
    (result_o.out_max_x == COORD_MAX) || (result_o.out_max_x == COORD_MIN) ||
    (result_o.out_max_y == COORD_MAX) || (result_o.out_max_y == COORD_MIN) ||
    (result_o.out_max_z == COORD_MAX) || (result_o.out_max_z == COORD_MIN);

  `AAT_ASSERT_NOW(a_word_out, took, ##4 valid_o, "accepted box gave no result")
  `AAT_ASSERT_NOW(a_no_extra, valid_o, $past(took, 4), "result without a box")
  `AAT_ASSERT_NOW(a_clip_sat, valid_o && result_o.clipped, edge_seen,
                  "clipped set but no bound at a limit")

endmodule

bind aabb_affine_transform_top aat_checker u_aat_checker (.*);
